>>> rtl/core/mmfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmfs_pkg: shared types and constants of the min-max feature scaler
// Field widths, divider operand widths, sequencer states and the id-to-slot
// reduction used by the statistics table.
// ----------------------------------------------------------------------------
package mmfs_pkg;

   localparam int MAX_ITEMS_DEF    = 64;
   localparam int NUM_FEATURES_DEF = 256;

   localparam int ID_W       = 8;
   localparam int VAL_W      = 32;
   localparam int FRAC_W     = 16;
   localparam int QUO_W      = FRAC_W + 1;
   localparam int DEN_W      = VAL_W;
   localparam int DIVIDEND_W = VAL_W + QUO_W;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LD_WR,
      ST_EM_BUF,
      ST_EM_TAB,
      ST_EM_PREP,
      ST_EM_DIV
   } mmfs_state_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DEN_W-1:0]      divisor;
   } mmfs_div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } mmfs_div_rsp_type;

   // id modulo n by shifted compare-subtract; n of 256 or more leaves id as is
   function automatic logic [ID_W-1:0] mmfs_id_slot(input logic [ID_W-1:0] id, input int n);
      logic [ID_W-1:0] r;
      r = id;
      for (int k = ID_W - 1; k >= 0; k--) begin
         if (n < (1 << ID_W)) begin
            if (int'(r) >= (n << k)) begin
               r = r - ID_W'(n << k);
            end
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/mmfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmfs_ram: single-port-write, single-port-read memory
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module mmfs_ram import mmfs_pkg::*; #(
   parameter int WIDTH = VAL_W,
   parameter int DEPTH = MAX_ITEMS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/mmfs_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmfs_divider: restoring divider, one quotient bit per cycle
// Dividend is known to give a quotient below 2**QUO_W, so the upper part
// starts as the partial remainder and QUO_W steps finish the division.
// ----------------------------------------------------------------------------
module mmfs_divider import mmfs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mmfs_div_req_type div_req,
   output mmfs_div_rsp_type      div_rsp
);

   localparam int CNT_W = $clog2(QUO_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0] low_ff, low_in;
   logic [QUO_W-1:0] quo_ff, quo_in;

   logic [DEN_W:0] shifted;
   logic [DEN_W:0] diff;
   logic           fits;

   always_comb begin
      shifted = {rem_ff, low_ff[QUO_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = !diff[DEN_W];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = div_req.dividend[DIVIDEND_W-1:QUO_W];
         low_in  = div_req.dividend[QUO_W-1:0];
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         low_in = {low_ff[QUO_W-2:0], 1'b0};
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a run");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff != CNT_W'(QUO_W - 1)) |=> busy_ff)
      else $error("divider stopped early");

endmodule
`default_nettype wire

>>> rtl/core/min_max_feature_scaler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_max_feature_scaler_unit: per-query min-max feature normalization
// Loading an entry takes a statistics-table read and then its update.
// On query end each buffered entry passes a buffer read, a table read, a prepare
// step and the bit-serial divider; an entry whose feature max equals min skips it.
// Results are strobed one cycle each and cannot be stalled by the receiver.
// After reset a clearing pass writes every table slot; busy is high meanwhile.
// ----------------------------------------------------------------------------
module min_max_feature_scaler_unit import mmfs_pkg::*; #(
   parameter int MAX_ITEMS    = MAX_ITEMS_DEF,
   parameter int NUM_FEATURES = NUM_FEATURES_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [ID_W-1:0]         req_feature_id,
   input  wire logic signed [VAL_W-1:0] req_value,
   input  wire logic                    req_doc_end,
   input  wire logic                    req_query_end,
   output logic                         rsp_valid,
   output logic [ID_W-1:0]              rsp_out_feature_id,
   output logic signed [VAL_W-1:0]      rsp_scaled_value,
   output logic                         rsp_out_doc_end,
   output logic                         rsp_last,
   output logic                         rsp_overflow
);

   localparam int IDX_W  = $clog2(MAX_ITEMS);
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int SLOT_W = $clog2(NUM_FEATURES);
   localparam int ENT_W  = ID_W + VAL_W + 1;
   localparam int STAT_W = 1 + 2 * VAL_W;

   mmfs_state_type state_ff, state_in;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    dropped_ff, dropped_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [SLOT_W-1:0]       clr_ff, clr_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic                    qend_ff, qend_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]         rsp_id_ff, rsp_id_in;
   logic [VAL_W-1:0]        rsp_val_ff, rsp_val_in;
   logic                    rsp_doc_ff, rsp_doc_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   logic              buf_wr_en;
   logic [IDX_W-1:0]  buf_wr_addr;
   logic [ENT_W-1:0]  buf_wr_data;
   logic              buf_rd_en;
   logic [ENT_W-1:0]  buf_rd_data;

   logic              stat_wr_en;
   logic [SLOT_W-1:0] stat_wr_addr;
   logic [STAT_W-1:0] stat_wr_data;
   logic              stat_rd_en;
   logic [SLOT_W-1:0] stat_rd_addr;
   logic [STAT_W-1:0] stat_rd_data;

   mmfs_div_req_type div_req;
   mmfs_div_rsp_type div_rsp;

   logic [15:0]             req_slot_ext;
   logic [15:0]             buf_slot_ext;
   logic [SLOT_W-1:0]       req_slot;
   logic [SLOT_W-1:0]       buf_slot;
   logic                    stat_seen;
   logic signed [VAL_W-1:0] stat_lo;
   logic signed [VAL_W-1:0] stat_hi;
   logic [ID_W-1:0]         ent_id;
   logic signed [VAL_W-1:0] ent_val;
   logic                    ent_doc;
   logic [VAL_W-1:0]        num;
   logic [VAL_W-1:0]        den;
   logic [CNT_W-1:0]        k_next;
   logic                    emit;
   logic [VAL_W-1:0]        emit_val;

   mmfs_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ITEMS)) u_entry_buf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (buf_wr_addr),
      .wr_data (buf_wr_data),
      .rd_en   (buf_rd_en),
      .rd_addr (k_ff[IDX_W-1:0]),
      .rd_data (buf_rd_data)
   );

   mmfs_ram #(.WIDTH(STAT_W), .DEPTH(NUM_FEATURES)) u_stat_table (
      .clock   (clock),
      .wr_en   (stat_wr_en),
      .wr_addr (stat_wr_addr),
      .wr_data (stat_wr_data),
      .rd_en   (stat_rd_en),
      .rd_addr (stat_rd_addr),
      .rd_data (stat_rd_data)
   );

   mmfs_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_slot_ext = 16'(mmfs_id_slot(req_feature_id, NUM_FEATURES));
   assign req_slot     = req_slot_ext[SLOT_W-1:0];

   assign ent_id       = buf_rd_data[ENT_W-1 -: ID_W];
   assign ent_val      = $signed(buf_rd_data[VAL_W:1]);
   assign ent_doc      = buf_rd_data[0];
   assign buf_slot_ext = 16'(mmfs_id_slot(ent_id, NUM_FEATURES));
   assign buf_slot     = buf_slot_ext[SLOT_W-1:0];

   assign stat_seen = stat_rd_data[STAT_W-1];
   assign stat_lo   = $signed(stat_rd_data[2*VAL_W-1:VAL_W]);
   assign stat_hi   = $signed(stat_rd_data[VAL_W-1:0]);

   assign num    = VAL_W'(ent_val - stat_lo);
   assign den    = VAL_W'(stat_hi - stat_lo);
   assign k_next = k_ff + CNT_W'(1);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      k_in       = k_ff;
      clr_in     = clr_ff;
      slot_in    = slot_ff;
      val_in     = val_ff;
      qend_in    = qend_ff;

      buf_wr_en    = 1'b0;
      buf_wr_addr  = count_ff[IDX_W-1:0];
      buf_wr_data  = {req_feature_id, req_value, req_doc_end};
      buf_rd_en    = 1'b0;
      stat_wr_en   = 1'b0;
      stat_wr_addr = slot_ff;
      stat_wr_data = '0;
      stat_rd_en   = 1'b0;
      stat_rd_addr = req_slot;

      div_req.start    = 1'b0;
      div_req.dividend = DIVIDEND_W'({num, FRAC_W'(0)}) + DIVIDEND_W'(den[VAL_W-1:1]);
      div_req.divisor  = den;

      emit     = 1'b0;
      emit_val = VAL_W'(div_rsp.quotient);

      case (state_ff)
         ST_CLEAR: begin
            stat_wr_en   = 1'b1;
            stat_wr_addr = clr_ff;
            clr_in       = clr_ff + SLOT_W'(1);
            if (clr_ff == SLOT_W'(NUM_FEATURES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               val_in  = req_value;
               qend_in = req_query_end;
               slot_in = req_slot;
               if (count_ff < CNT_W'(MAX_ITEMS)) begin
                  buf_wr_en  = 1'b1;
                  stat_rd_en = 1'b1;
                  state_in   = ST_LD_WR;
               end else begin
                  dropped_in = 1'b1;
                  k_in       = '0;
                  if (req_query_end) begin
                     state_in = ST_EM_BUF;
                  end
               end
            end
         end
         ST_LD_WR: begin
            stat_wr_en = 1'b1;
            if (!stat_seen) begin
               stat_wr_data = {1'b1, val_ff, val_ff};
            end else begin
               stat_wr_data = {1'b1,
                               (val_ff < stat_lo) ? val_ff : stat_lo,
                               (val_ff > stat_hi) ? val_ff : stat_hi};
            end
            count_in = count_ff + CNT_W'(1);
            k_in     = '0;
            state_in = qend_ff ? ST_EM_BUF : ST_IDLE;
         end
         ST_EM_BUF: begin
            buf_rd_en = 1'b1;
            state_in  = ST_EM_TAB;
         end
         ST_EM_TAB: begin
            stat_rd_en   = 1'b1;
            stat_rd_addr = buf_slot;
            slot_in      = buf_slot;
            state_in     = ST_EM_PREP;
         end
         ST_EM_PREP: begin
            // seen cleared here; min and max stay for later entries of this id
            stat_wr_en   = 1'b1;
            stat_wr_data = {1'b0, stat_lo, stat_hi};
            if (stat_hi == stat_lo) begin
               emit     = 1'b1;
               emit_val = stat_lo;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_EM_DIV;
            end
         end
         ST_EM_DIV: begin
            emit = div_rsp.done;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit;
      rsp_id_in    = ent_id;
      rsp_val_in   = emit_val;
      rsp_doc_in   = ent_doc;
      rsp_last_in  = (k_next == count_ff);
      rsp_ovf_in   = dropped_ff;

      if (emit) begin
         if (k_next == count_ff) begin
            count_in   = '0;
            dropped_in = 1'b0;
            k_in       = '0;
            state_in   = ST_IDLE;
         end else begin
            k_in     = k_next;
            state_in = ST_EM_BUF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         k_ff         <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         k_ff         <= k_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      val_ff      <= val_in;
      qend_ff     <= qend_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_doc_ff  <= rsp_doc_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_feature_id = rsp_id_ff;
   assign rsp_scaled_value   = $signed(rsp_val_ff);
   assign rsp_out_doc_end    = rsp_doc_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_overflow       = rsp_ovf_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_busy_mid_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("block idle before the last result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("entry count beyond buffer depth");

   a_no_result_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid && count_ff == '0)
      else $error("activity during clearing pass");

endmodule
`default_nettype wire
